// File: src/lirs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lirs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int RING_W     = 10;
  localparam int PHASE_W    = 21;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = 21;
  localparam int CHANNELS   = 2;
  localparam int IN_W       = CHANNELS * SAMPLE_W;
  localparam int OUT_FLD_W  = CHANNELS * SAMPLE_W + RING_W;
  localparam int OUT_W      = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam int RING_DEPTH_DEF  = 1024;
  localparam int MAX_OUTPUTS_DEF = 16;

  localparam logic [PHASE_W-1:0] ONE_Q16    = PHASE_W'(65536);
  localparam logic [PHASE_W-1:0] PHASE_MAX  = {PHASE_W{1'b1}};
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);

  localparam logic REG_STEP_RATIO = 1'b0;

  typedef enum logic {
    RS_IDLE,
    RS_EMIT
  } rs_state_t;

  typedef struct packed {
    logic prime;
    logic load;
    logic emit;
    logic skip;
  } rs_cmd_t;

  typedef struct packed {
    logic primed;
    logic phase_ge_one;
    logic out_free;
    logic emit_last;
  } rs_stat_t;

endpackage
`default_nettype wire

// File: src/linear_interp_resampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Stereo linear-interpolation sample-rate converter. The first frame after reset only primes
// the previous frame. Every later frame is accepted in the idle state and then produces its
// output frames (0 to MAX_OUTPUTS, set by the phase and step_ratio) in the emit state, or
// takes one skip step there when it produces none, before the next frame is accepted. The
// output rate is set by the single interpolation multiplier of each channel, which yields one
// output frame per cycle into the output register while that register is free. A new input
// frame is accepted while the last output of the previous one still waits in that register.
// step_ratio is the only register, at byte address 0, unsigned Q5.16.
module linear_interp_resampler_unit
  import lirs_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,  // left_in, right_in
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [OUT_W-1:0]  m_tdata,  // left_out, right_out, ring_index, zero fill
  output logic                   m_tlast,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [STEP_W-1:0] step_ratio;
  rs_cmd_t           cmd;
  rs_stat_t          stat;

  lirs_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .step_ratio (step_ratio)
  );

  lirs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lirs_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_data    (s_tdata),
    .step_ratio (step_ratio),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule
`default_nettype wire

// File: src/lirs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module lirs_cfg
  import lirs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [STEP_W-1:0] step_ratio
);

  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_STEP_RATIO);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= STEP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      step_ratio <= pwdata[STEP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = DATA_W'(step_ratio);
    end
  end

endmodule
`default_nettype wire

// File: src/lirs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lirs_ctrl
  import lirs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire rs_stat_t stat,
  output rs_cmd_t       cmd
);

  rs_state_t state;
  rs_state_t state_next;
  logic      in_beat;

  assign in_beat = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      RS_IDLE: begin
        if (in_beat && stat.primed) begin
          state_next = RS_EMIT;
        end
      end
      RS_EMIT: begin
        if (stat.phase_ge_one) begin
          state_next = RS_IDLE;
        end else if (stat.out_free && stat.emit_last) begin
          state_next = RS_IDLE;
        end
      end
      default: state_next = RS_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      RS_IDLE: begin
        s_tready  = 1'b1;
        cmd.prime = in_beat && !stat.primed;
        cmd.load  = in_beat && stat.primed;
      end
      RS_EMIT: begin
        cmd.skip = stat.phase_ge_one;
        cmd.emit = !stat.phase_ge_one && stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // An output frame is only produced into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("emit into an occupied output register");

  // A frame that starts interpolation always comes after the priming frame.
  a_emit_primed: assert property (@(posedge clk) disable iff (rst)
    (state == RS_EMIT) |-> stat.primed)
    else $error("interpolation without a previous frame");

  // A loaded frame is worked on in the following cycle.
  a_load_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == RS_EMIT) && !s_tready)
    else $error("loaded frame not processed");

endmodule
`default_nettype wire

// File: src/lirs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lirs_datapath
  import lirs_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [IN_W-1:0]   in_data,
  input  wire logic [STEP_W-1:0] step_ratio,
  input  wire rs_cmd_t           cmd,
  output rs_stat_t               stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [OUT_W-1:0]  out_data,
  output logic                   out_last
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int EXT_W  = (IDX_W > RING_W) ? IDX_W : RING_W;
  localparam int CNT_W  = $clog2(MAX_OUTPUTS + 1);
  localparam int PROD_W = 2 * SAMPLE_W + 2;
  localparam int SUM_W  = SAMPLE_W + 2;

  logic signed [SAMPLE_W-1:0] in_sample [CHANNELS];
  logic signed [SAMPLE_W-1:0] prev      [CHANNELS];
  logic signed [SAMPLE_W-1:0] cur       [CHANNELS];
  logic signed [SAMPLE_W-1:0] interp    [CHANNELS];
  logic signed [SAMPLE_W-1:0] out_sample[CHANNELS];

  logic               primed;
  logic [PHASE_W-1:0] phase;
  logic [IDX_W-1:0]   widx;
  logic [CNT_W-1:0]   cnt;
  logic [RING_W-1:0]  out_ring;

  logic [PHASE_W:0]   phase_sum;
  logic [PHASE_W-1:0] phase_sat;
  logic [PHASE_W-1:0] phase_drop;
  logic               emit_last;
  logic               out_free;
  logic [EXT_W-1:0]   widx_ext;
  logic [IDX_W-1:0]   widx_inc;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic signed [SAMPLE_W:0]  diff;
    logic signed [SAMPLE_W:0]  frac;
    logic signed [PROD_W-1:0]  prod;
    logic signed [SUM_W-1:0]   sum;

    assign in_sample[c] = in_data[c*SAMPLE_W +: SAMPLE_W];
    assign diff = (SAMPLE_W+1)'(cur[c]) - (SAMPLE_W+1)'(prev[c]);
    assign frac = signed'({1'b0, phase[FRAC_W-1:0]});
    assign prod = PROD_W'(diff) * PROD_W'(frac);
    assign sum  = SUM_W'(prev[c]) + signed'(prod[PROD_W-1:FRAC_W]);
    assign interp[c] = sum[SAMPLE_W-1:0];
  end

  assign phase_sum  = (PHASE_W+1)'(phase) + (PHASE_W+1)'(step_ratio);
  assign phase_sat  = phase_sum[PHASE_W] ? PHASE_MAX : phase_sum[PHASE_W-1:0];
  assign phase_drop = (phase_sat >= ONE_Q16) ? (phase_sat - ONE_Q16) : '0;
  assign emit_last  = (phase_sat >= ONE_Q16) || (cnt == CNT_W'(MAX_OUTPUTS - 1));
  assign out_free   = !out_valid || out_ready;
  assign widx_ext   = EXT_W'(widx);
  assign widx_inc   = (widx == IDX_W'(RING_DEPTH - 1)) ? '0 : widx + IDX_W'(1);

  assign stat.primed       = primed;
  assign stat.phase_ge_one = (phase >= ONE_Q16);
  assign stat.out_free     = out_free;
  assign stat.emit_last    = emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      phase     <= '0;
      widx      <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        prev[c] <= '0;
      end
    end else begin
      if (cmd.prime) begin
        primed <= 1'b1;
        prev   <= in_sample;
      end
      if (cmd.skip || (cmd.emit && emit_last)) begin
        prev <= cur;
      end
      if (cmd.skip) begin
        phase <= phase - ONE_Q16;
      end else if (cmd.emit) begin
        phase <= emit_last ? phase_drop : phase_sat;
        widx  <= widx_inc;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= in_sample;
      cnt <= '0;
    end else if (cmd.emit) begin
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.emit) begin
      out_sample <= interp;
      out_ring   <= widx_ext[RING_W-1:0];
      out_last   <= emit_last;
    end
  end

  always_comb begin
    out_data = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      out_data[c*SAMPLE_W +: SAMPLE_W] = out_sample[c];
    end
    out_data[CHANNELS*SAMPLE_W +: RING_W] = out_ring;
  end

  // The output count per frame never passes its cap.
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (cnt < CNT_W'(MAX_OUTPUTS)))
    else $error("too many outputs for one input frame");

  // The ring write index stays inside the ring.
  a_widx_range: assert property (@(posedge clk) disable iff (rst)
    widx <= IDX_W'(RING_DEPTH - 1))
    else $error("ring write index out of range");

  // Only a phase below one is interpolated.
  a_phase_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (phase < ONE_Q16))
    else $error("interpolation with phase at or above one");

endmodule
`default_nettype wire

// File: sim/lirs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lirs_checker
  import lirs_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,  // left_in, right_in
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [OUT_W-1:0]  m_tdata,  // left_out, right_out, ring_index, zero fill
  input  wire logic              m_tlast,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  input  wire logic [DATA_W-1:0] prdata,
  input  wire logic              pready,
  output int                     mismatches,
  output int                     frames_pending
);

  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [RING_W-1:0]   slot;
    logic                last;
  } out_frame_t;

  out_frame_t                 frames_due[$];
  logic        [STEP_W-1:0]   step_q16;
  logic signed [SAMPLE_W-1:0] prev_l;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic        [PHASE_W-1:0]  phase;
  int                         slot_idx;
  logic                       primed;

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [SAMPLE_W-1:0] lerp(input logic signed [SAMPLE_W-1:0] a,
                                               input logic signed [SAMPLE_W-1:0] b,
                                               input logic [PHASE_W-1:0] frac);
    longint prod;
    prod = (longint'(b) - longint'(a)) * longint'(frac);
    // Arithmetic shift of the signed product rounds toward minus infinity.
    return SAMPLE_W'(longint'(a) + (prod >>> FRAC_W));
  endfunction

  task automatic predict_frame(input logic signed [SAMPLE_W-1:0] cur_l,
                               input logic signed [SAMPLE_W-1:0] cur_r);
    out_frame_t         f;
    int                 n;
    logic [PHASE_W:0]   sum;
    logic [PHASE_W-1:0] next_phase;
    if (!primed) begin
      primed = 1'b1;
    end else begin
      n = 0;
      while (phase < ONE_Q16 && n < MAX_OUTPUTS) begin
        sum = {1'b0, phase} + {1'b0, step_q16};
        next_phase = (sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : sum[PHASE_W-1:0];
        f.left  = lerp(prev_l, cur_l, phase);
        f.right = lerp(prev_r, cur_r, phase);
        f.slot  = RING_W'(slot_idx);
        f.last  = (n + 1 == MAX_OUTPUTS) || (next_phase >= ONE_Q16);
        frames_due.push_back(f);
        slot_idx = (slot_idx + 1) % RING_DEPTH;
        phase = next_phase;
        n++;
      end
      phase = (phase >= ONE_Q16) ? phase - ONE_Q16 : '0;
    end
    prev_l = cur_l;
    prev_r = cur_r;
  endtask

  always @(posedge clk) begin
    out_frame_t want;
    if (rst) begin
      frames_due.delete();
      step_q16   = STEP_RESET;
      prev_l     = '0;
      prev_r     = '0;
      phase      = '0;
      slot_idx   = 0;
      primed     = 1'b0;
      mismatches = 0;
    end else begin
      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_STEP_RATIO) begin
        if (pwrite) begin
          step_q16 = pwdata[STEP_W-1:0];
        end else if (prdata[STEP_W-1:0] != step_q16) begin
          report($sformatf("step_ratio read %0d, expected %0d", prdata[STEP_W-1:0], step_q16));
        end
      end
      if (m_tvalid && m_tready) begin
        if (frames_due.size() == 0) begin
          report($sformatf("output beat %h with no frame expected", m_tdata));
        end else begin
          want = frames_due.pop_front();
          if (m_tdata[SAMPLE_W-1:0] != want.left)
            report($sformatf("left_out %h, expected %h", m_tdata[SAMPLE_W-1:0], want.left));
          if (m_tdata[2*SAMPLE_W-1:SAMPLE_W] != want.right)
            report($sformatf("right_out %h, expected %h", m_tdata[2*SAMPLE_W-1:SAMPLE_W],
                             want.right));
          if (m_tdata[2*SAMPLE_W+RING_W-1:2*SAMPLE_W] != want.slot)
            report($sformatf("ring_index %0d, expected %0d",
                             m_tdata[2*SAMPLE_W+RING_W-1:2*SAMPLE_W], want.slot));
          if (m_tlast != want.last)
            report($sformatf("tlast %b, expected %b at ring_index %0d", m_tlast, want.last,
                             want.slot));
        end
      end
      if (s_tvalid && s_tready) predict_frame(s_tdata[SAMPLE_W-1:0],
                                              s_tdata[2*SAMPLE_W-1:SAMPLE_W]);
    end
    frames_pending <= frames_due.size();
  end

endmodule
`default_nettype wire

// File: sim/tb_linear_interp_resampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_linear_interp_resampler_unit;
  import lirs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = MAX_OUTPUTS_DEF + 8;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 50;

  localparam logic                REG_SPARE  = 1'b1;
  localparam logic [ADDR_W-1:0]   STEP_ADDR  = {REG_STEP_RATIO, 2'b00};
  localparam logic [ADDR_W-1:0]   SPARE_ADDR = {REG_SPARE, 2'b00};
  localparam logic [SAMPLE_W-1:0] S_MAX      = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] S_MIN      = 16'h8000;
  localparam logic [SAMPLE_W-1:0] S_NEG1     = 16'hFFFF;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  wire               s_tready;
  logic [IN_W-1:0]   s_tdata;  // left_in, right_in
  wire               m_tvalid;
  logic              m_tready;
  wire  [OUT_W-1:0]  m_tdata;  // left_out, right_out, ring_index, zero fill
  wire               m_tlast;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  wire  [DATA_W-1:0] prdata;
  wire               pready;

  int mismatches;
  int frames_pending;
  int gap_pct;
  int stall_pct;
  bit long_hold_req;

  linear_interp_resampler_unit dut (.*);

  lirs_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return S_NEG1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tdata  <= {r, l};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Lets the block drain completely so the register can be touched safely.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_step(input logic [STEP_W-1:0] value);
    settle();
    apb_access(1'b1, STEP_ADDR, DATA_W'(value));
    apb_access(1'b0, STEP_ADDR, '0);
  endtask

  initial begin
    logic [STEP_W-1:0] step;
    rst           <= 1'b1;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    gap_pct       = 25;
    stall_pct     = 25;
    long_hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first frame only primes; with unit step each later frame yields its predecessor.
    apb_access(1'b0, STEP_ADDR, '0);
    set_step(STEP_W'(65536));
    send_frame('0, '0);
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame(S_MAX, S_MAX);
    send_frame(S_MIN, S_MIN);
    send_frame(S_NEG1, 16'h0001);

    // A write to an unused register index must leave the step alone.
    settle();
    apb_access(1'b1, SPARE_ADDR, DATA_W'(4096));
    apb_access(1'b0, STEP_ADDR, '0);
    send_frame(16'h1234, 16'hEDCB);
    send_frame(S_MIN, S_MAX);

    // Zero step and a step just under 1/16 hit the output cap below 1.0.
    set_step('0);
    send_frame(S_MAX, S_MIN);
    send_frame(16'h0100, 16'hFF00);
    set_step(STEP_W'(4095));
    send_frame(S_MIN, S_MAX);
    send_frame(S_MAX, S_MIN);
    set_step(STEP_W'(4096));
    send_frame(S_MIN, S_MAX);
    send_frame(S_MAX, S_MIN);

    // Fractional phases across full-scale swings exercise floor rounding.
    set_step(STEP_W'(45000));
    send_frame(S_MIN, S_MAX);
    send_frame(S_MAX, S_MIN);
    send_frame(16'h0001, S_NEG1);

    // Large steps skip frames; the largest one saturates the phase.
    set_step(STEP_W'(1048576));
    repeat (4) send_frame(rand_sample(), rand_sample());
    set_step({STEP_W{1'b1}});
    repeat (4) send_frame(rand_sample(), rand_sample());

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       step = STEP_W'(4096);
        2:       step = STEP_W'(1048576);
        3:       step = STEP_W'($urandom_range(0, (1 << STEP_W) - 1));
        5:       step = {STEP_W{1'b1}};
        9:       step = STEP_W'($urandom_range(16384, 98304));
        default: step = STEP_W'($urandom_range(4096, 200000));
      endcase
      set_step(step);
      gap_pct   = (p == 1 || p == PHASES - 1) ? 0 : 25;
      stall_pct = gap_pct;
      if (p == 0) long_hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_frame(rand_sample(), rand_sample());
    end

    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
src/lirs_pkg.sv
src/lirs_cfg.sv
src/lirs_ctrl.sv
src/lirs_datapath.sv
src/linear_interp_resampler_unit.sv
sim/lirs_checker.sv
sim/tb_linear_interp_resampler_unit.sv
